### rtl/tdce_pkg.sv
// Package of the text display command engine.
// Holds the cell layout, the blank cell value and the command codes.
// It has no dependencies.
package tdce_pkg;

    // One screen cell as stored: character and both colors, before the cursor swap.
    typedef struct packed {
        logic [6:0] ch;
        logic [5:0] fg;
        logic [5:0] bg;
    } cell_t;

    localparam cell_t BLANK_CELL = '{ch: 7'd32, fg: 6'd63, bg: 6'd0};

    // Command codes.
    localparam logic [3:0] MODE_WRITE_ADV = 4'd0;
    localparam logic [3:0] MODE_CLEAR     = 4'd1;
    localparam logic [3:0] MODE_MOVE      = 4'd2;
    localparam logic [3:0] MODE_WRITE     = 4'd3;
    localparam logic [3:0] MODE_SET_COL   = 4'd4;
    localparam logic [3:0] MODE_SET_ROW   = 4'd5;
    localparam logic [3:0] MODE_POS_HIGH  = 4'd6;
    localparam logic [3:0] MODE_POS_LOW   = 4'd7;
    localparam logic [3:0] MODE_VISIBLE   = 4'd8;
    localparam logic [3:0] MODE_COLOR     = 4'd9;

    // Clear selectors.
    localparam logic [7:0] CLR_SCREEN   = 8'd0;
    localparam logic [7:0] CLR_ROW      = 8'd1;
    localparam logic [7:0] CLR_NEXT_ROW = 8'd2;

endpackage

### rtl/text_display_command_engine_core.sv
// Top level of the text display command engine.
// Uses tdce_pkg and the cell memory tdce_cell_ram.

// Takes one command per transfer and returns one result per command. A new
// command is taken only in the idle state, once the result of the last one has
// been loaded into the output register. A character or color write adds a
// read-modify-write of the cursor cell. Cursor moves that need a remainder run
// a loop of one add or subtract a cycle and then a final step that stores the
// result. Relative and full position moves then split the cell into row and
// column by repeated subtraction of COLUMNS. Clearing a row blanks COLUMNS cells
// and clearing the screen COLUMNS*ROWS cells, one cell a cycle through the
// memory write port. After reset the same pass clears the screen before the
// first command transfer is taken. The cursor swap of colors is applied when a
// cell is read out.
module text_display_command_engine_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 30
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data, [19:8] read_position, [23:20] zero
    input  logic [3:0]  s_tuser,   // [3:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [6:0] cell_char, [12:7] cell_fg, [18:13] cell_bg,
                                   // [30:19] cursor_position, [31] cursor_off
);
    import tdce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW = $clog2(CELLS);
    localparam int CLW = $clog2(COLUMNS);
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXEC  = 8'b0000_0010,
        S_WB    = 8'b0000_0100,
        S_CLR   = 8'b0000_1000,
        S_RED   = 8'b0001_0000,
        S_SPLIT = 8'b0010_0000,
        S_RRD   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]  mode_reg;
    logic [7:0]  data_reg;
    logic [11:0] rp_reg;
    logic [7:0]  hi_reg, hi_next;
    logic        hidden_reg, hidden_next;
    logic [CLW-1:0] col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [AW-1:0]  clr_ptr_reg, clr_ptr_next;
    logic [16:0]    clr_cnt_reg, clr_cnt_next;
    logic           boot_reg, boot_next;
    logic signed [17:0] red_reg, red_next;
    logic [16:0]    mod_reg, mod_next;
    logic [16:0]    spl_reg, spl_next;
    logic           m_tvalid_reg;
    logic [31:0]    m_tdata_reg;

    logic [AW-1:0] cur_cell;
    logic [AW-1:0] rp_addr;
    logic          rp_in_range;
    logic          out_free;
    logic [RW-1:0] next_row;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    cell_t         ram_wdata;
    cell_t         ram_rdata;
    cell_t         shown;

    assign cur_cell    = AW'(int'(row_reg) * COLUMNS + int'(col_reg));
    assign rp_addr     = AW'(rp_reg);
    assign rp_in_range = (32'(rp_reg) < CELLS);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign next_row    = (32'(row_reg) == ROWS - 1) ? RW'(0) : RW'(row_reg + 1'b1);
    assign s_tready    = (state_reg == S_IDLE);
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign ram_raddr   = (state_reg == S_EXEC) ? cur_cell : rp_addr;

    tdce_cell_ram #(.DEPTH(CELLS), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Command sequencer.
    always_comb
    begin
        state_next   = state_reg;
        hi_next      = hi_reg;
        hidden_next  = hidden_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        clr_ptr_next = clr_ptr_reg;
        clr_cnt_next = clr_cnt_reg;
        boot_next    = boot_reg;
        red_next     = red_reg;
        mod_next     = mod_reg;
        spl_next     = spl_reg;
        ram_we       = 1'b0;
        ram_waddr    = cur_cell;
        ram_wdata    = ram_rdata;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RRD;
                case (mode_reg) inside
                    MODE_WRITE_ADV, MODE_WRITE, MODE_COLOR:
                    begin
                        state_next = S_WB;
                    end
                    MODE_CLEAR:
                    begin
                        if (data_reg == CLR_SCREEN)
                        begin
                            row_next     = '0;
                            col_next     = '0;
                            clr_ptr_next = '0;
                            clr_cnt_next = 17'(CELLS);
                            state_next   = S_CLR;
                        end
                        else if (data_reg == CLR_ROW)
                        begin
                            col_next     = '0;
                            clr_ptr_next = AW'(int'(row_reg) * COLUMNS);
                            clr_cnt_next = 17'(COLUMNS);
                            state_next   = S_CLR;
                        end
                        else if (data_reg == CLR_NEXT_ROW)
                        begin
                            col_next     = '0;
                            row_next     = next_row;
                            clr_ptr_next = AW'(int'(next_row) * COLUMNS);
                            clr_cnt_next = 17'(COLUMNS);
                            state_next   = S_CLR;
                        end
                    end
                    MODE_MOVE:
                    begin
                        red_next   = $signed({1'b0, 17'(cur_cell)})
                                   + 18'(signed'(data_reg));
                        mod_next   = 17'(CELLS);
                        state_next = S_RED;
                    end
                    MODE_SET_COL:
                    begin
                        red_next   = 18'(data_reg);
                        mod_next   = 17'(COLUMNS);
                        state_next = S_RED;
                    end
                    MODE_SET_ROW:
                    begin
                        red_next   = 18'(data_reg);
                        mod_next   = 17'(ROWS);
                        state_next = S_RED;
                    end
                    MODE_POS_HIGH:
                    begin
                        hi_next = data_reg;
                    end
                    MODE_POS_LOW:
                    begin
                        red_next   = 18'({hi_reg, data_reg});
                        mod_next   = 17'(CELLS);
                        state_next = S_RED;
                    end
                    MODE_VISIBLE:
                    begin
                        hidden_next = (data_reg != 8'd0);
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WB:
            begin
                // Modify the cursor cell read in the previous cycle.
                ram_we     = 1'b1;
                ram_waddr  = cur_cell;
                state_next = S_RRD;
                if (mode_reg == MODE_COLOR)
                begin
                    if (data_reg[6])
                    begin
                        ram_wdata.bg = data_reg[5:0];
                    end
                    else
                    begin
                        ram_wdata.fg = data_reg[5:0];
                    end
                end
                else
                begin
                    ram_wdata.ch = data_reg[6:0];
                end
                if (mode_reg == MODE_WRITE_ADV || (mode_reg == MODE_COLOR && data_reg[7]))
                begin
                    if (32'(col_reg) == COLUMNS - 1)
                    begin
                        col_next = '0;
                        row_next = next_row;
                    end
                    else
                    begin
                        col_next = CLW'(col_reg + 1'b1);
                    end
                end
            end
            S_CLR:
            begin
                // Blank one cell a cycle.
                ram_we       = 1'b1;
                ram_waddr    = clr_ptr_reg;
                ram_wdata    = BLANK_CELL;
                clr_ptr_next = AW'(clr_ptr_reg + 1'b1);
                clr_cnt_next = 17'(clr_cnt_reg - 1'b1);
                if (clr_cnt_reg == 17'd1)
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_RRD;
                end
            end
            S_RED:
            begin
                // Remainder by repeated add or subtract of the modulus.
                if (red_reg < 0)
                begin
                    red_next = red_reg + $signed({1'b0, mod_reg});
                end
                else if (red_reg >= $signed({1'b0, mod_reg}))
                begin
                    red_next = red_reg - $signed({1'b0, mod_reg});
                end
                else if (mode_reg == MODE_SET_COL)
                begin
                    col_next   = CLW'(red_reg);
                    state_next = S_RRD;
                end
                else if (mode_reg == MODE_SET_ROW)
                begin
                    row_next   = RW'(red_reg);
                    state_next = S_RRD;
                end
                else
                begin
                    spl_next   = 17'(red_reg);
                    row_next   = '0;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                // Split a cell index into row and column.
                if (spl_reg >= 17'(COLUMNS))
                begin
                    spl_next = 17'(spl_reg - 17'(COLUMNS));
                    row_next = RW'(row_reg + 1'b1);
                end
                else
                begin
                    col_next   = CLW'(spl_reg);
                    state_next = S_RRD;
                end
            end
            S_RRD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Displayed colors of the read cell: swapped under a shown cursor, all zero beyond the screen.
    always_comb
    begin
        shown = ram_rdata;
        if (!hidden_reg && rp_addr == cur_cell)
        begin
            shown.fg = ram_rdata.bg;
            shown.bg = ram_rdata.fg;
        end
        if (!rp_in_range)
        begin
            shown = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            hi_reg       <= '0;
            hidden_reg   <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            clr_ptr_reg  <= '0;
            clr_cnt_reg  <= 17'(CELLS);
            boot_reg     <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hi_reg      <= hi_next;
            hidden_reg  <= hidden_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            clr_ptr_reg <= clr_ptr_next;
            clr_cnt_reg <= clr_cnt_next;
            boot_reg    <= boot_next;
            if (state_reg == S_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        red_reg <= red_next;
        mod_reg <= mod_next;
        spl_reg <= spl_next;
        if (s_tvalid && s_tready)
        begin
            mode_reg <= s_tuser;
            data_reg <= s_tdata[7:0];
            rp_reg   <= s_tdata[19:8];
        end
        if (state_reg == S_OUT && out_free)
        begin
            m_tdata_reg <= {hidden_reg, 12'(cur_cell), shown.bg, shown.fg, shown.ch};
        end
    end

    // Checks.
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_cell) < CELLS)
        else $error("cursor cell beyond the screen");

    a_wb_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WB |-> $past(state_reg) == S_EXEC)
        else $error("cell write-back without a cursor read");

    a_boot_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        boot_reg |-> !s_tready)
        else $error("input taken during the clearing pass");

    a_result_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result without a cell read");

endmodule

### rtl/tdce_cell_ram.sv
// Screen cell memory of the text display command engine.
// One write port and one read port with registered read data.
// Depends on tdce_pkg for the cell layout.
module tdce_cell_ram #(
    parameter int DEPTH = 2400,
    parameter int AW = 12
) (
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  tdce_pkg::cell_t wdata,
    input  logic [AW-1:0]  raddr,
    output tdce_pkg::cell_t rdata
);
    import tdce_pkg::*;

    cell_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, old data on a same-address write.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### test/tb_text_display_command_engine_core.sv
// Testbench of the text display command engine core.
// Depends on tdce_pkg and text_display_command_engine_core; holds its own screen model.

module tb_text_display_command_engine_core;
    import tdce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS = 80;
    localparam int ROWS_N = 30;
    localparam int CELLS = COLS * ROWS_N;
    localparam longint LIMIT = 3000000;

    typedef struct packed {
        logic [3:0]  mode;
        logic [7:0]  data;
        logic [11:0] rpos;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  ch;
        logic [5:0]  fg;
        logic [5:0]  bg;
        logic [11:0] cur;
        logic        off;
    } view_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] data, [19:8] read_position, [23:20] zero
    logic [3:0]  s_tuser;   // [3:0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [6:0] char, [12:7] fg, [18:13] bg, [30:19] cursor, [31] off

    // Screen model state, colors kept as displayed.
    logic [6:0]  scr_ch [CELLS];
    logic [5:0]  scr_fg [CELLS];
    logic [5:0]  scr_bg [CELLS];
    int          cur_cell;
    logic [7:0]  pos_high;
    logic        hidden;

    cmd_t  pending_cmds[$];
    view_t expected_views[$];
    int    errors;
    int    results_seen;
    int    cmds_sent;
    longint cycles;
    bit    stim_done;
    bit    calm;
    int    hold_off;

    text_display_command_engine_core #(.COLUMNS(COLS), .ROWS(ROWS_N)) dut (.*);

    always #5 clk = ~clk;

    // Swap colors of the cursor cell while the cursor is shown.
    function automatic void flip_cursor();
        logic [5:0] t;
        if (hidden || cur_cell >= CELLS)
            return;
        t = scr_fg[cur_cell];
        scr_fg[cur_cell] = scr_bg[cur_cell];
        scr_bg[cur_cell] = t;
    endfunction

    function automatic void blank(int p);
        if (p >= CELLS)
            return;
        scr_ch[p] = 7'd32;
        scr_fg[p] = 6'd63;
        scr_bg[p] = 6'd0;
    endfunction

    function automatic void wipe_screen();
        for (int i = 0; i < CELLS; i++)
            blank(i);
        cur_cell = 0;
        flip_cursor();
    endfunction

    // Apply one command to the model and return what the block should report.
    function automatic view_t screen_apply(cmd_t c);
        view_t v;
        int col;
        int np;
        col = cur_cell % COLS;
        case (c.mode)
            MODE_WRITE_ADV:
            begin
                scr_ch[cur_cell] = c.data[6:0];
                flip_cursor();
                cur_cell = (cur_cell + 1) % CELLS;
                flip_cursor();
            end
            MODE_CLEAR:
            begin
                if (c.data == CLR_SCREEN)
                    wipe_screen();
                else if (c.data == CLR_ROW)
                begin
                    cur_cell -= col;
                    for (int i = 0; i < COLS; i++)
                        blank(cur_cell + i);
                    flip_cursor();
                end
                else if (c.data == CLR_NEXT_ROW)
                begin
                    flip_cursor();
                    cur_cell = (cur_cell - col + COLS) % CELLS;
                    for (int i = 0; i < COLS; i++)
                        blank(cur_cell + i);
                    flip_cursor();
                end
            end
            MODE_MOVE:
            begin
                np = (cur_cell + int'($signed(c.data))) % CELLS;
                if (np < 0)
                    np += CELLS;
                flip_cursor();
                cur_cell = np;
                flip_cursor();
            end
            MODE_WRITE:
                scr_ch[cur_cell] = c.data[6:0];
            MODE_SET_COL:
            begin
                flip_cursor();
                cur_cell = cur_cell - col + int'(c.data) % COLS;
                flip_cursor();
            end
            MODE_SET_ROW:
            begin
                flip_cursor();
                cur_cell = (int'(c.data) % ROWS_N) * COLS + col;
                flip_cursor();
            end
            MODE_POS_HIGH:
                pos_high = c.data;
            MODE_POS_LOW:
            begin
                flip_cursor();
                cur_cell = int'({pos_high, c.data}) % CELLS;
                flip_cursor();
            end
            MODE_VISIBLE:
            begin
                flip_cursor();
                hidden = (c.data != 0);
                flip_cursor();
            end
            MODE_COLOR:
            begin
                flip_cursor();
                if (!c.data[6])
                    scr_fg[cur_cell] = c.data[5:0];
                else
                    scr_bg[cur_cell] = c.data[5:0];
                if (c.data[7])
                    cur_cell = (cur_cell + 1) % CELLS;
                flip_cursor();
            end
            default: ;
        endcase
        if (c.rpos < CELLS)
        begin
            v.ch = scr_ch[c.rpos];
            v.fg = scr_fg[c.rpos];
            v.bg = scr_bg[c.rpos];
        end
        else
        begin
            v.ch = '0;
            v.fg = '0;
            v.bg = '0;
        end
        v.cur = cur_cell[11:0];
        v.off = hidden;
        return v;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
    endtask

    // Rough cursor neighborhood used only to aim reads near recent writes.
    int guess_cur;
    function automatic int cur_guess();
        return (guess_cur + $urandom_range(0, 3)) % CELLS;
    endfunction

    function automatic logic [11:0] rand_rpos();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 12'($urandom_range(CELLS, 4095));
        if (r < 8)
            return 12'(cur_guess());
        return 12'($urandom_range(0, CELLS - 1));
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int r;
        r = $urandom_range(0, 99);
        c.data = 8'($urandom);
        if (r < 30)
            c.mode = MODE_WRITE_ADV;
        else if (r < 36)
            c.mode = MODE_WRITE;
        else if (r < 48)
            c.mode = MODE_COLOR;
        else if (r < 56)
            c.mode = MODE_MOVE;
        else if (r < 61)
            c.mode = MODE_SET_COL;
        else if (r < 66)
            c.mode = MODE_SET_ROW;
        else if (r < 72)
            c.mode = MODE_POS_HIGH;
        else if (r < 79)
            c.mode = MODE_POS_LOW;
        else if (r < 85)
        begin
            c.mode = MODE_VISIBLE;
            if ($urandom_range(0, 1) == 0)
                c.data = '0;
        end
        else if (r < 93)
        begin
            // Mostly row clears; full clears kept rare since they walk the screen.
            c.mode = MODE_CLEAR;
            r = $urandom_range(0, 19);
            c.data = (r == 0) ? CLR_SCREEN : (r < 8) ? CLR_ROW : (r < 15) ? CLR_NEXT_ROW
                     : 8'($urandom_range(3, 255));
        end
        else
            c.mode = 4'($urandom_range(10, 15));
        if (c.mode == MODE_POS_HIGH && $urandom_range(0, 1) == 0)
            c.data = 8'($urandom_range(0, 9));
        c.rpos = rand_rpos();
        return c;
    endfunction

    function automatic cmd_t mk(logic [3:0] m, logic [7:0] d, logic [11:0] p);
        cmd_t c;
        c.mode = m;
        c.data = d;
        c.rpos = p;
        return c;
    endfunction

    // Stimulus: a directed opening, then random commands.
    initial
    begin
        clk = 0;
        rst_n = 0;
        errors = 0;
        results_seen = 0;
        cmds_sent = 0;
        cycles = 0;
        stim_done = 0;
        calm = 0;
        hold_off = 0;
        guess_cur = 0;
        hidden = 0;
        pos_high = '0;
        wipe_screen();
        pending_cmds.push_back(mk(4'd15, 8'd0, 12'd0));
        pending_cmds.push_back(mk(MODE_WRITE_ADV, 8'hFF, 12'd0));
        pending_cmds.push_back(mk(MODE_WRITE_ADV, 8'h00, 12'd1));
        pending_cmds.push_back(mk(MODE_WRITE, 8'h41, 12'd2));
        pending_cmds.push_back(mk(MODE_MOVE, 8'h80, 12'hFFF));
        pending_cmds.push_back(mk(MODE_MOVE, 8'h7F, 12'd2399));
        pending_cmds.push_back(mk(MODE_MOVE, 8'hFF, 12'd2400));
        pending_cmds.push_back(mk(MODE_SET_COL, 8'hFF, 12'd0));
        pending_cmds.push_back(mk(MODE_SET_ROW, 8'hFF, 12'd0));
        pending_cmds.push_back(mk(MODE_SET_ROW, 8'd29, 12'd0));
        pending_cmds.push_back(mk(MODE_CLEAR, CLR_NEXT_ROW, 12'd0));
        pending_cmds.push_back(mk(MODE_POS_HIGH, 8'hFF, 12'd0));
        pending_cmds.push_back(mk(MODE_POS_LOW, 8'hFF, 12'd0));
        pending_cmds.push_back(mk(MODE_POS_HIGH, 8'h09, 12'd0));
        pending_cmds.push_back(mk(MODE_POS_LOW, 8'h5F, 12'd2399));
        pending_cmds.push_back(mk(MODE_COLOR, 8'hFF, 12'd2399));
        pending_cmds.push_back(mk(MODE_COLOR, 8'h3F, 12'd0));
        pending_cmds.push_back(mk(MODE_COLOR, 8'h80, 12'd0));
        pending_cmds.push_back(mk(MODE_VISIBLE, 8'h80, 12'd1));
        pending_cmds.push_back(mk(MODE_WRITE_ADV, 8'h5A, 12'd1));
        pending_cmds.push_back(mk(MODE_VISIBLE, 8'h00, 12'd2));
        pending_cmds.push_back(mk(MODE_CLEAR, CLR_ROW, 12'd1));
        pending_cmds.push_back(mk(MODE_CLEAR, 8'hFF, 12'd0));
        pending_cmds.push_back(mk(MODE_CLEAR, 8'd3, 12'd0));
        pending_cmds.push_back(mk(MODE_CLEAR, CLR_SCREEN, 12'd0));
        for (int i = 0; i < 1450; i++)
            pending_cmds.push_back(random_cmd());
        repeat (6) @(posedge clk);
        rst_n <= 1;
        stim_done = 1;
    end

    // Driver: offers queued commands, idling now and then.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                cmds_sent++;
                expected_views.push_back(screen_apply(pending_cmds.pop_front()));
                guess_cur = cur_cell;
            end
            if ((!s_tvalid || s_tready) && pending_cmds.size() > 0
                && (calm || $urandom_range(0, 99) >= 9))
            begin
                s_tvalid <= 1;
                s_tdata  <= {4'd0, pending_cmds[0].rpos, pending_cmds[0].data};
                s_tuser  <= pending_cmds[0].mode;
            end
            else if (!s_tvalid || s_tready)
                s_tvalid <= 0;
        end
    end

    // Receiver readiness: random stalls, one long hold-off, one calm stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 0;
        else
        begin
            calm <= (cmds_sent >= 400 && cmds_sent < 700);
            if (cmds_sent == 200 && hold_off == 0)
                hold_off <= 300;
            if (hold_off > 1)
            begin
                hold_off <= hold_off - 1;
                m_tready <= 0;
            end
            else
            begin
                if (hold_off == 1)
                    hold_off <= -1;
                m_tready <= calm || $urandom_range(0, 99) >= 9;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        view_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_views.size() == 0)
            begin
                report_mismatch("unexpected transfer", int'(m_tdata), 0);
            end
            else
            begin
                w = expected_views.pop_front();
                if (m_tdata[6:0] !== w.ch)
                    report_mismatch("cell_char", m_tdata[6:0], w.ch);
                if (m_tdata[12:7] !== w.fg)
                    report_mismatch("cell_fg", m_tdata[12:7], w.fg);
                if (m_tdata[18:13] !== w.bg)
                    report_mismatch("cell_bg", m_tdata[18:13], w.bg);
                if (m_tdata[30:19] !== w.cur)
                    report_mismatch("cursor_position", m_tdata[30:19], w.cur);
                if (m_tdata[31] !== w.off)
                    report_mismatch("cursor_off", m_tdata[31], w.off);
            end
        end
    end

    // Watchdog and end of run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done);
        wait (pending_cmds.size() == 0 && !s_tvalid && expected_views.size() == 0);
        repeat (3000) @(posedge clk);
        $display("Ran %0d commands through every mode, with stalls on both sides,", cmds_sent);
        $display("and checked %0d results against the screen model.", results_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
rtl/tdce_pkg.sv
rtl/tdce_cell_ram.sv
rtl/text_display_command_engine_core.sv
test/tb_text_display_command_engine_core.sv
